// ===== rtl/prq_pkg.sv =====
// Package for the pending request queue: transaction structs, operation and status codes.
// It also holds the default sizes.
// It has no dependencies.
package prq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TagBitsDefault    = 8;
  localparam int unsigned FieldTagW         = 8;
  localparam int unsigned FieldCntW         = 5;

  typedef enum logic [1:0] {
    OP_PUSH        = 2'd0,
    OP_POP         = 2'd1,
    OP_CANCEL_PROC = 2'd2,
    OP_CANCEL_FILE = 2'd3
  } prq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } prq_status_e;

  typedef struct packed {
    prq_op_e                opcode;
    logic [FieldTagW-1:0]   process_tag;
    logic [FieldTagW-1:0]   file_tag;
  } prq_req_t;

  typedef struct packed {
    prq_status_e            status;
    logic [FieldTagW-1:0]   head_process;
    logic [FieldTagW-1:0]   head_file;
    logic [FieldCntW-1:0]   removed_count;
    logic [FieldCntW-1:0]   occupancy;
  } prq_rsp_t;

endpackage

// ===== rtl/prq_ring.sv =====
// Entry storage of the pending request queue: one synchronous memory used as a ring.
// Offsets are taken relative to the head slot; the read data is registered.
// It depends on no package.
module prq_ring #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 16
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] head_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_off_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_off_i,
  input  logic [DataW-1:0] wr_data_i
);

  localparam logic [AddrW:0] DepthL = (AddrW+1)'(Depth);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;
  logic [AddrW:0]   rd_sum;
  logic [AddrW:0]   wr_sum;
  logic [AddrW:0]   rd_wrap;
  logic [AddrW:0]   wr_wrap;

  always_comb begin
    rd_sum  = {1'b0, head_i} + {1'b0, rd_off_i};
    wr_sum  = {1'b0, head_i} + {1'b0, wr_off_i};
    rd_wrap = (rd_sum >= DepthL) ? rd_sum - DepthL : rd_sum;
    wr_wrap = (wr_sum >= DepthL) ? wr_sum - DepthL : wr_sum;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_wrap[AddrW-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_wrap[AddrW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/pending_request_queue_with_cancel.sv =====
// Top level of the pending request queue with push, pop and cancel by tag.
// It depends on prq_pkg and on the entry storage in prq_ring.
//
// Channel    Direction  Handshake             Payload
// request    in         start high, busy low  req_i (prq_req_t)
// response   out        done_o strobe         rsp_o (prq_rsp_t)
//
// A push and a pop or cancel on an empty queue answer in the cycle after acceptance.
// Other pops go through StPop: the head entry is read from the synchronous memory.
// Other cancels walk the entry memory in StScan, one read per cycle,
// and write each kept entry back to its compacted slot.
// After reset the queue is empty; the entry memory needs no clearing pass.
// A response is shown for one cycle only and the receiver cannot stall it.
module pending_request_queue_with_cancel #(
  parameter int unsigned QUEUE_DEPTH = prq_pkg::QueueDepthDefault,
  parameter int unsigned TAG_BITS    = prq_pkg::TagBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  prq_pkg::prq_req_t  req_i,
  output logic               done_o,
  output prq_pkg::prq_rsp_t  rsp_o
);
  import prq_pkg::*;

  localparam int unsigned AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TagW  = (TAG_BITS < FieldTagW) ? TAG_BITS : FieldTagW;
  localparam int unsigned DataW = 2 * TagW;
  localparam logic [CntW-1:0]  DepthC   = CntW'(QUEUE_DEPTH);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(QUEUE_DEPTH - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPop  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  rd_q, rd_d;
  logic [CntW-1:0]  wr_q, wr_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [TagW-1:0]  key_q, key_d;
  logic             by_file_q, by_file_d;
  logic             done_q, done_d;
  prq_rsp_t         rsp_q, rsp_d;

  logic             accept;
  logic [TagW-1:0]  in_proc;
  logic [TagW-1:0]  in_file;
  logic             rd_en;
  logic [AddrW-1:0] rd_off;
  logic             wr_en;
  logic [AddrW-1:0] wr_off;
  logic [DataW-1:0] wr_data;
  logic [DataW-1:0] rd_data;
  logic [TagW-1:0]  rd_proc;
  logic [TagW-1:0]  rd_file;
  logic             match;
  logic [CntW-1:0]  rd_next;
  logic [CntW-1:0]  wr_next;
  logic [CntW-1:0]  rem_next;

  prq_ring #(
    .Depth (QUEUE_DEPTH),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_ring (
    .clk_i     (clk_i),
    .head_i    (head_q),
    .rd_en_i   (rd_en),
    .rd_off_i  (rd_off),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_off_i  (wr_off),
    .wr_data_i (wr_data)
  );

  assign busy    = (state_q != StIdle);
  assign accept  = start && !busy;
  assign in_proc = req_i.process_tag[TagW-1:0];
  assign in_file = req_i.file_tag[TagW-1:0];
  assign rd_proc = rd_data[DataW-1:TagW];
  assign rd_file = rd_data[TagW-1:0];
  assign match   = by_file_q ? (rd_file == key_q) : (rd_proc == key_q);
  assign rd_next = rd_q + CntW'(1);
  assign wr_next = match ? wr_q : wr_q + CntW'(1);
  assign rem_next = match ? rem_q + CntW'(1) : rem_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    head_d    = head_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    rem_d     = rem_q;
    key_d     = key_q;
    by_file_d = by_file_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    rd_en     = 1'b0;
    rd_off    = '0;
    wr_en     = 1'b0;
    wr_off    = '0;
    wr_data   = {in_proc, in_file};

    case (state_q)
      StIdle: begin
        if (accept) begin
          rsp_d.status        = ST_OK;
          rsp_d.head_process  = '0;
          rsp_d.head_file     = '0;
          rsp_d.removed_count = '0;
          rsp_d.occupancy     = FieldCntW'(count_q);
          case (req_i.opcode)
            OP_PUSH: begin
              done_d = 1'b1;
              if (count_q == DepthC) begin
                rsp_d.status = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_off          = count_q[AddrW-1:0];
                count_d         = count_q + CntW'(1);
                rsp_d.occupancy = FieldCntW'(count_q + CntW'(1));
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = StPop;
              end
            end
            default: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_d      = '0;
                wr_d      = '0;
                rem_d     = '0;
                by_file_d = (req_i.opcode == OP_CANCEL_FILE);
                key_d     = (req_i.opcode == OP_CANCEL_FILE) ? in_file : in_proc;
                state_d   = StScan;
              end
            end
          endcase
        end
      end
      StPop: begin
        done_d             = 1'b1;
        rsp_d.head_process = FieldTagW'(rd_proc);
        rsp_d.head_file    = FieldTagW'(rd_file);
        rsp_d.occupancy    = FieldCntW'(count_q - CntW'(1));
        count_d            = count_q - CntW'(1);
        head_d             = (head_q == LastSlot) ? '0 : head_q + AddrW'(1);
        state_d            = StIdle;
      end
      StScan: begin
        wr_data = rd_data;
        wr_off  = wr_q[AddrW-1:0];
        wr_en   = !match;
        wr_d    = wr_next;
        rem_d   = rem_next;
        if (rd_next == count_q) begin
          done_d              = 1'b1;
          count_d             = wr_next;
          rsp_d.removed_count = FieldCntW'(rem_next);
          rsp_d.occupancy     = FieldCntW'(wr_next);
          state_d             = StIdle;
        end else begin
          rd_en  = 1'b1;
          rd_off = rd_next[AddrW-1:0];
          rd_d   = rd_next;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    wr_q      <= wr_d;
    rem_q     <= rem_d;
    key_q     <= key_d;
    by_file_q <= by_file_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("Queue occupancy exceeds its depth.");

  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (count_q != '0) && (rd_q < count_q) && (wr_q <= rd_q))
    else $error("Cancel walk indexes are out of order.");

  a_accept_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o || busy)
    else $error("An accepted transaction neither answered nor started work.");

  a_done_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("The block went idle without a response.");

endmodule
